>>> rtl/core/slt_pkg.sv
package slt_pkg;

  localparam int LIST_SIZE_DEF = 128;
  localparam int DATA_W        = 32;
  localparam int POS_W         = 8;
  localparam int KIND_W        = 3;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_CLEAR  = 3'd0;
  localparam kind_t KIND_INSERT = 3'd1;
  localparam kind_t KIND_DELETE = 3'd2;
  localparam kind_t KIND_GET    = 3'd3;
  localparam kind_t KIND_LOCATE = 3'd4;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_CLEAR,
    CELL_INSERT,
    CELL_DELETE
  } cell_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_APPLY,
    ST_POST,
    ST_REPORT
  } state_t;

  typedef struct packed {
    cell_mode_t        mode;
    logic [DATA_W-1:0] val;
  } cell_ctl_t;

  typedef struct packed {
    logic clr;
    logic pre;
    logic post;
    logic want_elem;
    logic want_find;
  } scan_ctl_t;

endpackage

>>> rtl/core/slt_cell.sv
module slt_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  slt_pkg::cell_ctl_t        ctl,
  input  logic [IW-1:0]             idx,
  input  logic [slt_pkg::DATA_W-1:0] left_d,
  input  logic [slt_pkg::DATA_W-1:0] right_d,
  output logic [slt_pkg::DATA_W-1:0] data_q
);
  import slt_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              above;
  logic              at;

  assign above = MY_IDX > idx;
  assign at    = MY_IDX == idx;

  always_comb begin
    data_nxt = data_r;
    case (ctl.mode)
      CELL_ROTATE: data_nxt = right_d;
      CELL_CLEAR:  data_nxt = '0;
      CELL_INSERT: begin
        if (above) begin
          data_nxt = left_d;
        end else if (at) begin
          data_nxt = ctl.val;
        end
      end
      CELL_DELETE: begin
        if (above || at) begin
          data_nxt = right_d;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_q = data_r;

endmodule

>>> rtl/core/slt_ctrl.sv
module slt_ctrl #(
  parameter int LIST_SIZE = slt_pkg::LIST_SIZE_DEF,
  parameter int IW        = $clog2(LIST_SIZE)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  slt_pkg::kind_t             in_kind,
  input  logic [slt_pkg::POS_W-1:0]  in_position,
  input  logic [slt_pkg::DATA_W-1:0] in_value,
  output slt_pkg::cell_ctl_t         cell_ctl,
  output slt_pkg::scan_ctl_t         scan_ctl,
  output logic [IW-1:0]              idx,
  output logic [IW-1:0]              step,
  output logic                       report
);
  import slt_pkg::*;

  localparam int CW = $clog2(LIST_SIZE + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [IW-1:0] LAST_STEP = IW'(LIST_SIZE - 1);

  state_t            state_r;
  state_t            state_nxt;
  logic [IW-1:0]     step_r;
  logic [IW-1:0]     step_nxt;
  kind_t             kind_r;
  logic              ok_r;
  logic [IW-1:0]     idx_r;
  logic [DATA_W-1:0] val_r;
  logic [PW-1:0]     pos_w;
  logic              pos_ok;
  logic              accept;
  logic              last;

  assign pos_w  = PW'(in_position);
  assign pos_ok = (pos_w != '0) && (pos_w <= PW'(LIST_SIZE));
  assign busy   = !((state_r == ST_IDLE) || (state_r == ST_REPORT));
  assign accept = start && !busy;
  assign last   = step_r == LAST_STEP;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   state_nxt = accept ? ST_PRE : ST_IDLE;
      ST_PRE:    state_nxt = last ? ST_APPLY : ST_PRE;
      ST_APPLY:  state_nxt = ST_POST;
      ST_POST:   state_nxt = last ? ST_REPORT : ST_POST;
      ST_REPORT: state_nxt = accept ? ST_PRE : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    step_nxt = '0;
    if (((state_r == ST_PRE) || (state_r == ST_POST)) && !last) begin
      step_nxt = step_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      ok_r   <= pos_ok;
      idx_r  <= IW'(pos_w - PW'(1));
      val_r  <= in_value;
    end
  end

  always_comb begin
    cell_ctl.mode = CELL_HOLD;
    cell_ctl.val  = val_r;
    case (state_r)
      ST_PRE, ST_POST: cell_ctl.mode = CELL_ROTATE;
      ST_APPLY: begin
        if (kind_r == KIND_CLEAR) begin
          cell_ctl.mode = CELL_CLEAR;
        end else if ((kind_r == KIND_INSERT) && ok_r) begin
          cell_ctl.mode = CELL_INSERT;
        end else if ((kind_r == KIND_DELETE) && ok_r) begin
          cell_ctl.mode = CELL_DELETE;
        end
      end
      default: cell_ctl.mode = CELL_HOLD;
    endcase

    scan_ctl.clr       = accept;
    scan_ctl.pre       = state_r == ST_PRE;
    scan_ctl.post      = state_r == ST_POST;
    scan_ctl.want_elem = ok_r && ((kind_r == KIND_GET) || (kind_r == KIND_DELETE));
    scan_ctl.want_find = kind_r == KIND_LOCATE;
  end

  assign idx    = idx_r;
  assign step   = step_r;
  assign report = state_r == ST_REPORT;

endmodule

>>> rtl/core/slt_scan.sv
module slt_scan #(
  parameter int LIST_SIZE = slt_pkg::LIST_SIZE_DEF,
  parameter int IW        = $clog2(LIST_SIZE)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  slt_pkg::scan_ctl_t         ctl,
  input  logic [IW-1:0]              step,
  input  logic [IW-1:0]              idx,
  input  logic [slt_pkg::DATA_W-1:0] val,
  input  logic [slt_pkg::DATA_W-1:0] head,
  output logic [slt_pkg::DATA_W-1:0] element,
  output logic [slt_pkg::POS_W-1:0]  found_position,
  output logic [slt_pkg::POS_W-1:0]  length
);
  import slt_pkg::*;

  localparam int CW = $clog2(LIST_SIZE + 1);

  logic [DATA_W-1:0] elem_r;
  logic [CW-1:0]     found_r;
  logic              hit_r;
  logic [CW-1:0]     len_r;
  logic              run_r;

  // The ring passes each slot through cell 0 once per pass, in slot order,
  // so step names the slot that sits at the head in this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      run_r <= 1'b0;
    end else if (ctl.clr) begin
      elem_r  <= '0;
      found_r <= '0;
      hit_r   <= 1'b0;
      len_r   <= '0;
      run_r   <= 1'b1;
    end else begin
      if (ctl.pre && ctl.want_elem && (step == idx)) begin
        elem_r <= head;
      end
      if (ctl.pre && ctl.want_find && !hit_r && (head == val)) begin
        found_r <= CW'(step) + CW'(1);
        hit_r   <= 1'b1;
      end
      if (ctl.post && run_r) begin
        if (head != '0) begin
          len_r <= len_r + CW'(1);
        end else begin
          run_r <= 1'b0;
        end
      end
    end
  end

  assign element        = elem_r;
  assign found_position = POS_W'(found_r);
  assign length         = POS_W'(len_r);

endmodule

>>> rtl/core/sequential_list_table_unit.sv
// Channel  Ports                                            Handshake
// input    in_kind, in_position, in_value                   start & !busy
// result   out_element, out_found_position, out_length,     out_valid, one cycle
//          out_empty_res
//
// An operation steps from the accepting edge through the ST_PRE, ST_APPLY,
// ST_POST and ST_REPORT states, and a new one is taken at the edge that
// ends the out_valid cycle. The ring of slot cells rotates twice through
// the head cell: once on the old contents, once after the shift.
// rst_n is synchronous and clears every slot; the receiver cannot stall.
module sequential_list_table_unit #(
  parameter int LIST_SIZE = slt_pkg::LIST_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [slt_pkg::KIND_W-1:0]        in_kind,
  input  logic [slt_pkg::POS_W-1:0]         in_position,
  input  logic signed [slt_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  output logic signed [slt_pkg::DATA_W-1:0] out_element,
  output logic [slt_pkg::POS_W-1:0]         out_found_position,
  output logic [slt_pkg::POS_W-1:0]         out_length,
  output logic                              out_empty_res
);
  import slt_pkg::*;

  localparam int IW = $clog2(LIST_SIZE);

  cell_ctl_t         cell_ctl;
  scan_ctl_t         scan_ctl;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     step;
  logic [DATA_W-1:0] cell_q [LIST_SIZE];
  logic [DATA_W-1:0] wrap_d;
  logic [DATA_W-1:0] elem;

  slt_ctrl #(
    .LIST_SIZE (LIST_SIZE),
    .IW        (IW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_kind     (in_kind),
    .in_position (in_position),
    .in_value    (in_value),
    .cell_ctl    (cell_ctl),
    .scan_ctl    (scan_ctl),
    .idx         (idx),
    .step        (step),
    .report      (out_valid)
  );

  // The top cell refills from the head while rotating and from zero on delete.
  assign wrap_d = (cell_ctl.mode == CELL_ROTATE) ? cell_q[0] : '0;

  for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end

    if (i == LIST_SIZE - 1) begin : g_last
      assign right_d = wrap_d;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end

    slt_cell #(
      .INDEX (i),
      .IW    (IW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl),
      .idx     (idx),
      .left_d  (left_d),
      .right_d (right_d),
      .data_q  (cell_q[i])
    );
  end

  slt_scan #(
    .LIST_SIZE (LIST_SIZE),
    .IW        (IW)
  ) u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (scan_ctl),
    .step           (step),
    .idx            (idx),
    .val            (cell_ctl.val),
    .head           (cell_q[0]),
    .element        (elem),
    .found_position (out_found_position),
    .length         (out_length)
  );

  assign out_element   = elem;
  assign out_empty_res = cell_q[0] == '0;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an operation in flight");

  a_empty_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_res) |-> (out_length == '0))
    else $error("empty list reported with nonzero length");
`endif

endmodule

>>> verif/sequential_list_table_unit_test.sv
`timescale 1ns / 100ps

module sequential_list_table_unit_test;
  import slt_pkg::*;

  localparam int LIST_SIZE = LIST_SIZE_DEF;
  localparam kind_t KIND_LAST = 3'd7;
  localparam int RANDOM_ITEMS = 1870;
  localparam int TAIL_ITEMS = 200;
  localparam int OP_CYCLES = 2 * LIST_SIZE + 2;
  localparam int QUIET_LIMIT = 8 * OP_CYCLES + 64;

  typedef struct {
    logic [DATA_W-1:0] element;
    logic [POS_W-1:0]  found;
    logic [POS_W-1:0]  length;
    logic              empty;
  } list_result_t;

  class list_scoreboard;
    logic [DATA_W-1:0] slots [LIST_SIZE];
    list_result_t expected_q [$];
    int errors;
    int checked;
    int max_len;
    int full_inserts;
    int kind_seen [8];

    function new();
      foreach (slots[i]) slots[i] = '0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      errors = 0;
      checked = 0;
      max_len = 0;
      full_inserts = 0;
    endfunction

    function int length_now();
      int n;
      n = 0;
      while (n < LIST_SIZE && slots[n] != '0) n++;
      return n;
    endfunction

    function logic [DATA_W-1:0] slot_value(int pos);
      return slots[pos-1];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Applies one accepted operation to the shadow list and queues its result.
    function void note(kind_t kind, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
      list_result_t r;
      bit pos_ok;
      int idx;
      r.element = '0;
      r.found = '0;
      pos_ok = (pos >= 1) && (pos <= LIST_SIZE);
      idx = int'(pos) - 1;
      kind_seen[kind]++;
      case (kind)
        KIND_CLEAR: begin
          foreach (slots[i]) slots[i] = '0;
        end
        KIND_INSERT: begin
          if (pos_ok) begin
            if (slots[LIST_SIZE-1] != '0) full_inserts++;
            for (int k = LIST_SIZE - 1; k > idx; k--) slots[k] = slots[k-1];
            slots[idx] = val;
          end
        end
        KIND_DELETE: begin
          if (pos_ok) begin
            r.element = slots[idx];
            for (int k = idx; k + 1 < LIST_SIZE; k++) slots[k] = slots[k+1];
            slots[LIST_SIZE-1] = '0;
          end
        end
        KIND_GET: begin
          if (pos_ok) r.element = slots[idx];
        end
        KIND_LOCATE: begin
          for (int k = 0; k < LIST_SIZE; k++) begin
            if (slots[k] == val) begin
              r.found = POS_W'(k + 1);
              break;
            end
          end
        end
        default: ;
      endcase
      r.length = POS_W'(length_now());
      r.empty = (slots[0] == '0);
      if (length_now() > max_len) max_len = length_now();
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check(logic [DATA_W-1:0] element, logic [POS_W-1:0] found,
                        logic [POS_W-1:0] length, logic empty);
      list_result_t r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, element 0x%0h length %0d",
                 $time, element, length);
        return;
      end
      r = expected_q.pop_front();
      checked++;
      compare_field("element", r.element, element);
      compare_field("found_position", DATA_W'(r.found), DATA_W'(found));
      compare_field("length", DATA_W'(r.length), DATA_W'(length));
      compare_field("empty_res", DATA_W'(r.empty), DATA_W'(empty));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [KIND_W-1:0] in_kind;
  logic [POS_W-1:0] in_position;
  logic signed [DATA_W-1:0] in_value;
  logic out_valid;
  logic signed [DATA_W-1:0] out_element;
  logic [POS_W-1:0] out_found_position;
  logic [POS_W-1:0] out_length;
  logic out_empty_res;

  list_scoreboard sb;
  int quiet_cycles = 0;

  sequential_list_table_unit #(
    .LIST_SIZE(LIST_SIZE)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_position(in_position),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_element(out_element),
    .out_found_position(out_found_position),
    .out_length(out_length),
    .out_empty_res(out_empty_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check(out_element, out_found_position, out_length, out_empty_res);
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Holds one beat on the input ports until the block takes it.
  task automatic issue(kind_t kind, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
    start <= 1'b1;
    in_kind <= kind;
    in_position <= pos;
    in_value <= val;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note(kind, pos, val);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    if ($urandom_range(0, 1) == 1)
      do @(posedge clk); while (busy !== 1'b0);
    repeat ($urandom_range(1, 17)) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3, 4: return DATA_W'($urandom_range(1, 12));
      default: return $urandom();
    endcase
  endfunction

  // Mostly well-formed operations on positions inside the current list,
  // with a small share of noise: wild positions, zero values, undefined kinds.
  task automatic random_op(int grow_pct, int del_pct);
    int len;
    int top;
    int roll;
    kind_t kind;
    logic [POS_W-1:0] pos;
    logic [DATA_W-1:0] val;
    len = sb.length_now();
    top = (len == 0) ? 1 : len;
    roll = $urandom_range(0, 99);
    val = pick_value();
    if (roll < 7) begin
      kind = kind_t'($urandom_range(KIND_INSERT, KIND_LAST));
      pos = POS_W'($urandom());
      if ($urandom_range(0, 3) == 0) val = '0;
    end else if (roll < 7 + grow_pct) begin
      kind = KIND_INSERT;
      pos = POS_W'($urandom_range(1, (len < LIST_SIZE) ? len + 1 : LIST_SIZE));
      if (val == '0) val = 32'd1;
    end else if (roll < 7 + grow_pct + del_pct) begin
      kind = KIND_DELETE;
      pos = POS_W'($urandom_range(1, top));
    end else if ($urandom_range(0, 1) == 0) begin
      kind = KIND_GET;
      pos = POS_W'($urandom_range(1, top));
    end else begin
      kind = KIND_LOCATE;
      pos = POS_W'($urandom());
      if (len > 0 && $urandom_range(0, 2) != 0) val = sb.slot_value($urandom_range(1, len));
    end
    issue(kind, pos, val);
  endtask

  initial begin
    int done;
    int round_len;
    int grow_pct;
    int del_pct;
    int idle_pct;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_CLEAR;
    in_position = '0;
    in_value = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty list, extremes, out-of-range positions, top slot.
    issue(KIND_GET, 8'd1, 32'd0);
    issue(KIND_LOCATE, 8'd0, 32'd0);
    issue(KIND_DELETE, 8'd1, 32'd0);
    issue(KIND_INSERT, 8'd1, 32'h7FFF_FFFF);
    issue(KIND_INSERT, 8'd1, 32'h8000_0000);
    issue(KIND_INSERT, 8'd2, 32'hFFFF_FFFF);
    issue(KIND_INSERT, 8'd4, 32'd1);
    issue(KIND_INSERT, 8'd0, 32'd5);
    issue(KIND_INSERT, 8'd129, 32'd6);
    issue(KIND_INSERT, 8'd255, 32'd7);
    issue(KIND_GET, 8'd4, 32'd0);
    issue(KIND_GET, 8'd0, 32'd0);
    issue(KIND_GET, 8'd128, 32'd0);
    issue(KIND_GET, 8'd255, 32'd0);
    issue(KIND_LOCATE, 8'd3, 32'hFFFF_FFFF);
    issue(KIND_LOCATE, 8'd1, 32'd12345);
    issue(KIND_LOCATE, 8'd1, 32'd0);
    issue(KIND_INSERT, 8'd128, 32'd9);
    issue(KIND_LOCATE, 8'd0, 32'd9);
    issue(KIND_DELETE, 8'd128, 32'd0);
    issue(KIND_DELETE, 8'd0, 32'd0);
    issue(KIND_DELETE, 8'd2, 32'd0);
    for (int k = KIND_LOCATE + 1; k <= KIND_LAST; k++)
      issue(kind_t'(k), POS_W'($urandom()), $urandom());
    issue(KIND_INSERT, 8'd2, 32'd0);
    issue(KIND_CLEAR, 8'd200, 32'hDEAD_BEEF);
    drain();

    done = 0;
    while (done < RANDOM_ITEMS) begin
      round_len = $urandom_range(40, 160);
      case ($urandom_range(0, 2))
        0: begin grow_pct = 80; del_pct = 5; end
        1: begin grow_pct = 10; del_pct = 60; end
        default: begin grow_pct = 35; del_pct = 25; end
      endcase
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if ($urandom_range(0, 5) == 0) issue(KIND_CLEAR, POS_W'($urandom()), $urandom());
      if (RANDOM_ITEMS - done > TAIL_ITEMS && $urandom_range(0, 2) == 0) drain();
      for (int i = 0; i < round_len && done < RANDOM_ITEMS; i++) begin
        random_op(grow_pct, del_pct);
        done++;
        if (RANDOM_ITEMS - done > TAIL_ITEMS && $urandom_range(0, 99) < idle_pct)
          idle_burst();
      end
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (OP_CYCLES + 8) @(posedge clk);

    $display("Ran %0d clears, %0d inserts, %0d deletes, %0d gets, %0d locates and %0d %s",
             sb.kind_seen[KIND_CLEAR], sb.kind_seen[KIND_INSERT], sb.kind_seen[KIND_DELETE],
             sb.kind_seen[KIND_GET], sb.kind_seen[KIND_LOCATE],
             sb.kind_seen[5] + sb.kind_seen[6] + sb.kind_seen[7], "undefined kinds.");
    $display("Checked %0d result beats; longest list %0d slots, %0d inserts into a full list.",
             sb.checked, sb.max_len, sb.full_inserts);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
